### rtl/llrb_pkg.sv
// Package for the line log ring buffer: constants, state type and control bundles.
`default_nettype none

package llrb_pkg;

  localparam int DEF_LINE_SLOTS = 64;
  localparam int DEF_LINE_BYTES = 80;

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 6;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 7;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;

  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_COPY,
    ST_COPY_END,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic take_item;
    logic append;
    logic copy_step;
    logic copy_end;
    logic rd_addr;
    logic rd_mem;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_read;
    logic is_term;
    logic pend_empty;
    logic pend_full;
    logic copy_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

### rtl/llrb_ctrl.sv
// Controller state machine for the line log ring buffer.
`default_nettype none

module llrb_ctrl import llrb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd,
  output logic           in_ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.is_read) begin
          state_next = ST_RD_ADDR;
        end else if (sts.is_term && !sts.pend_empty) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        if (sts.copy_last) state_next = ST_COPY_END;
      end
      ST_COPY_END: state_next = ST_DONE;
      ST_RD_ADDR:  state_next = ST_RD_MEM;
      ST_RD_MEM:   state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      ST_DECODE:   cmd.append = !sts.is_read && !sts.is_term && !sts.pend_full;
      ST_COPY:     cmd.copy_step = 1'b1;
      ST_COPY_END: cmd.copy_end = 1'b1;
      ST_RD_ADDR:  cmd.rd_addr = 1'b1;
      ST_RD_MEM:   cmd.rd_mem = 1'b1;
      ST_DONE:     cmd.load_out = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/llrb_datapath.sv
// Datapath of the line log ring buffer: pending line, ring store, counters, result register.
`default_nettype none

module llrb_datapath import llrb_pkg::*; #(
  parameter int LINE_SLOTS = DEF_LINE_SLOTS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctrl_cmd_t          cmd,
  output ctrl_sts_t               sts,
  input  wire logic               in_command,
  input  wire logic [CHAR_W-1:0]  in_char,
  input  wire logic [INDEX_W-1:0] in_index,
  input  wire logic [POS_W-1:0]   in_pos,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [CHAR_W-1:0]       out_byte,
  output logic [COUNT_W-1:0]      out_held,
  output logic [COUNT_W-1:0]      out_pending
);

  localparam int DEPTH = LINE_SLOTS * LINE_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(LINE_SLOTS);
  localparam int PW    = $clog2(LINE_BYTES);
  localparam int HW    = $clog2(LINE_SLOTS + 1);
  localparam int CW    = (HW > INDEX_W) ? HW : INDEX_W;
  localparam int QW    = (PW + 1 > POS_W) ? PW + 1 : POS_W;

  logic [CHAR_W-1:0] store [DEPTH];
  logic [CHAR_W-1:0] pend_mem [LINE_BYTES];

  logic               item_cmd;
  logic [CHAR_W-1:0]  item_char;
  logic [INDEX_W-1:0] item_index;
  logic [POS_W-1:0]   item_pos;

  logic [SW-1:0] write_slot;
  logic [AW-1:0] row_base;
  logic [HW-1:0] held;
  logic [PW-1:0] pend_count;
  logic [AW-1:0] clr_addr;

  logic [PW-1:0]     rd_pos;
  logic [PW-1:0]     wr_pos;
  logic              wr_valid;
  logic [CHAR_W-1:0] pend_q;

  logic [SW-1:0]     slot_q;
  logic              oob_q;
  logic [AW-1:0]     raddr_q;
  logic [CHAR_W-1:0] store_q;

  logic              store_we;
  logic [AW-1:0]     store_waddr;
  logic [CHAR_W-1:0] store_wdata;

  logic [SW:0]   start_ext;
  logic [SW:0]   slot_sum;
  logic [SW-1:0] slot_calc;
  logic          oob_calc;
  logic          last_slot;

  assign last_slot = (write_slot == SW'(LINE_SLOTS - 1));

  assign sts.clear_done = (clr_addr == AW'(DEPTH - 1));
  assign sts.is_read    = (item_cmd == CMD_READ);
  assign sts.is_term    = (item_char == CH_LF) || (item_char == CH_CR);
  assign sts.pend_empty = (pend_count == '0);
  assign sts.pend_full  = (pend_count == PW'(LINE_BYTES - 1));
  assign sts.copy_last  = (rd_pos == pend_count);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_cmd   <= in_command;
      item_char  <= in_char;
      item_index <= in_index;
      item_pos   <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step && !sts.clear_done) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      row_base   <= '0;
      held       <= '0;
      pend_count <= '0;
      rd_pos     <= '0;
      wr_valid   <= 1'b0;
    end else begin
      wr_valid <= cmd.copy_step;
      if (cmd.append) begin
        pend_count <= pend_count + PW'(1);
      end
      if (cmd.copy_step) begin
        rd_pos <= rd_pos + PW'(1);
      end
      if (cmd.copy_end) begin
        rd_pos     <= '0;
        pend_count <= '0;
        if (last_slot) begin
          write_slot <= '0;
          row_base   <= '0;
        end else begin
          write_slot <= write_slot + SW'(1);
          row_base   <= row_base + AW'(LINE_BYTES);
        end
        if (held != HW'(LINE_SLOTS)) begin
          held <= held + HW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      pend_mem[pend_count] <= item_char;
    end
    pend_q <= pend_mem[rd_pos];
    wr_pos <= rd_pos;
  end

  always_comb begin
    store_we    = 1'b0;
    store_waddr = row_base + AW'(wr_pos);
    store_wdata = (wr_pos == pend_count) ? CH_NUL : pend_q;
    if (cmd.clear_step) begin
      store_we    = 1'b1;
      store_waddr = clr_addr;
      store_wdata = CH_NUL;
    end else if (wr_valid) begin
      store_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_waddr] <= store_wdata;
    end
    if (cmd.rd_mem) begin
      store_q <= store[raddr_q];
    end
  end

  always_comb begin
    start_ext = (held == HW'(LINE_SLOTS)) ? {1'b0, write_slot} : '0;
    slot_sum  = start_ext + (SW + 1)'(item_index);
    slot_calc = (slot_sum >= (SW + 1)'(LINE_SLOTS)) ?
                SW'(slot_sum - (SW + 1)'(LINE_SLOTS)) : SW'(slot_sum);
    oob_calc  = (CW'(item_index) >= CW'(held)) ||
                (QW'(item_pos) >= QW'(LINE_BYTES));
  end

  always_ff @(posedge clk) begin
    slot_q <= slot_calc;
    oob_q  <= oob_calc;
    if (cmd.rd_addr) begin
      raddr_q <= AW'(slot_q) * AW'(LINE_BYTES) + AW'(item_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte    <= (sts.is_read && !oob_q) ? store_q : CH_NUL;
      out_held    <= COUNT_W'(held);
      out_pending <= COUNT_W'(pend_count);
    end
  end

endmodule

`default_nettype wire

### rtl/log_line_ring_buffer_core.sv
// Append: accept in IDLE, DECODE, DONE; line commit: DECODE, COPY per pending byte and NUL,
// COPY_END, DONE; read: DECODE, RD_ADDR, RD_MEM, DONE. DONE waits until the output register is
// free. One item is worked at a time; the longest item is a commit of LINE_BYTES-1 characters,
// paced by the one-byte-per-cycle copy loop from the pending-line memory into the ring store.
// After rst the ring store, LINE_SLOTS*LINE_BYTES bytes (5120 with the defaults), is cleared
// one byte per cycle while s_tready stays low; counters and the write slot reset to zero.
`default_nettype none

module log_line_ring_buffer_core import llrb_pkg::*; #(
  parameter int LINE_SLOTS = DEF_LINE_SLOTS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // char_in, line_index, char_pos, zero pad
  input  wire logic                  s_tuser,   // command
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // read_byte, lines_held, pending_length, zero pad
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic [CHAR_W-1:0]  read_byte;
  logic [COUNT_W-1:0] lines_held;
  logic [COUNT_W-1:0] pending_length;

  llrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  llrb_datapath #(
    .LINE_SLOTS (LINE_SLOTS),
    .LINE_BYTES (LINE_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_command  (s_tuser),
    .in_char     (s_tdata[7:0]),
    .in_index    (s_tdata[13:8]),
    .in_pos      (s_tdata[20:14]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_byte    (read_byte),
    .out_held    (lines_held),
    .out_pending (pending_length)
  );

  assign m_tdata = {2'b00, pending_length, lines_held, read_byte};

endmodule

`default_nettype wire
